FILE: design/assert_macros.svh
// assertion macros used by the rasteriser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/dda_pkg.sv
// shared types, constants and helpers for the dda line rasteriser
package dda_pkg;

    localparam int COORD_W        = 6;
    localparam int COLOR_W        = 4;
    localparam int DEF_COORD_BITS = 6;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] color;
    } seg_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } pixel_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // queue entry: {color, neg_y, neg_x, len, ady, adx, y0, x0}
    function automatic int seg_width(input int coord_bits);
        return 5 * coord_bits + 2 + COLOR_W;
    endfunction

endpackage

FILE: design/dda_front.sv
// front end: takes segments, works out deltas, length and step directions
module dda_front #(
    parameter int COORD_BITS = dda_pkg::DEF_COORD_BITS
) (
    input  logic                                       start,
    input  dda_pkg::seg_in_t                           segment,
    input  dda_pkg::queue_stat_t                       q_stat,
    output logic                                       busy,
    output logic                                       push,
    output logic [dda_pkg::seg_width(COORD_BITS)-1:0]  entry
);
    import dda_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0] x0, y0, x1, y1;
    logic [C-1:0] adx, ady, len;
    logic         neg_x, neg_y;

    always_comb
    begin
        x0    = segment.start_x[C-1:0];
        y0    = segment.start_y[C-1:0];
        x1    = segment.end_x[C-1:0];
        y1    = segment.end_y[C-1:0];
        neg_x = x1 < x0;
        neg_y = y1 < y0;
        adx   = neg_x ? (x0 - x1) : (x1 - x0);
        ady   = neg_y ? (y0 - y1) : (y1 - y0);
        len   = (adx >= ady) ? adx : ady;
    end

    assign busy  = q_stat.full;
    assign push  = start && !q_stat.full;
    assign entry = {segment.color, neg_y, neg_x, len, ady, adx, y0, x0};

endmodule

FILE: design/dda_queue.sv
// short first-word fall-through queue between front and back ends
module dda_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dda_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rd_data,
    output dda_pkg::queue_stat_t q_stat
);
    import dda_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

endmodule

FILE: design/dda_back.sv
// back end: per-axis restoring divide, then one pixel per cycle
module dda_back #(
    parameter int COORD_BITS = dda_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  dda_pkg::queue_stat_t                       q_stat,
    input  logic [dda_pkg::seg_width(COORD_BITS)-1:0]  entry,
    output logic                                       pop,
    output logic                                       strobe,
    output dda_pkg::pixel_out_t                        pixel
);
    import dda_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int F         = FRAC_BITS;
    localparam int A         = C + F;
    localparam int Q         = F + 1;
    localparam int DIV_CNT_W = $clog2(F + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(F);
    localparam logic [A-1:0]         HALF     = A'(1) << (F - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DRAW
    } state_t;

    state_t               state_reg;
    logic [C-1:0]         len_reg;
    logic [C-1:0]         cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [C:0]           rem_x_reg, rem_y_reg;
    logic [Q-1:0]         q_x_reg, q_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [A-1:0]         inc_x_reg, inc_y_reg;
    logic [A-1:0]         acc_x_reg, acc_y_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 strobe_reg;
    pixel_out_t           pixel_reg;

    // unpacked queue entry
    logic [C-1:0]       e_x0, e_y0, e_adx, e_ady, e_len;
    logic               e_neg_x, e_neg_y;
    logic [COLOR_W-1:0] e_color;

    assign e_x0    = entry[C-1:0];
    assign e_y0    = entry[2*C-1:C];
    assign e_adx   = entry[3*C-1:2*C];
    assign e_ady   = entry[4*C-1:3*C];
    assign e_len   = entry[5*C-1:4*C];
    assign e_neg_x = entry[5*C];
    assign e_neg_y = entry[5*C+1];
    assign e_color = entry[5*C+2+COLOR_W-1:5*C+2];

    // one quotient bit per axis per cycle
    logic [C:0]   len_ext;
    logic         bit_x, bit_y;
    logic [C:0]   diff_x, diff_y;
    logic [Q-1:0] q_x_step, q_y_step;
    logic [A-1:0] q_x_wide, q_y_wide;
    logic [A-1:0] round_x, round_y;

    always_comb
    begin
        len_ext  = {1'b0, len_reg};
        bit_x    = rem_x_reg >= len_ext;
        bit_y    = rem_y_reg >= len_ext;
        diff_x   = rem_x_reg - (bit_x ? len_ext : '0);
        diff_y   = rem_y_reg - (bit_y ? len_ext : '0);
        q_x_step = {q_x_reg[Q-2:0], bit_x};
        q_y_step = {q_y_reg[Q-2:0], bit_y};
        q_x_wide = A'(q_x_step);
        q_y_wide = A'(q_y_step);
        round_x  = acc_x_reg + HALF;
        round_y  = acc_y_reg + HALF;
    end

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            strobe_reg  <= 1'b0;
            pixel_reg   <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            div_cnt_reg <= '0;
            rem_x_reg   <= '0;
            rem_y_reg   <= '0;
            q_x_reg     <= '0;
            q_y_reg     <= '0;
            neg_x_reg   <= 1'b0;
            neg_y_reg   <= 1'b0;
            inc_x_reg   <= '0;
            inc_y_reg   <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            color_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        len_reg     <= e_len;
                        cnt_reg     <= '0;
                        div_cnt_reg <= '0;
                        rem_x_reg   <= {1'b0, e_adx};
                        rem_y_reg   <= {1'b0, e_ady};
                        q_x_reg     <= '0;
                        q_y_reg     <= '0;
                        neg_x_reg   <= e_neg_x;
                        neg_y_reg   <= e_neg_y;
                        inc_x_reg   <= '0;
                        inc_y_reg   <= '0;
                        acc_x_reg   <= {e_x0, F'(0)};
                        acc_y_reg   <= {e_y0, F'(0)};
                        color_reg   <= e_color;
                        // a point needs no divide
                        state_reg   <= (e_len == '0) ? ST_DRAW : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    q_x_reg     <= q_x_step;
                    q_y_reg     <= q_y_step;
                    rem_x_reg   <= {diff_x[C-1:0], 1'b0};
                    rem_y_reg   <= {diff_y[C-1:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        inc_x_reg <= neg_x_reg ? (A'(0) - q_x_wide) : q_x_wide;
                        inc_y_reg <= neg_y_reg ? (A'(0) - q_y_wide) : q_y_wide;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_DRAW:
                begin
                    strobe_reg            <= 1'b1;
                    pixel_reg.pixel_x     <= COORD_W'(round_x[A-1:F]);
                    pixel_reg.pixel_y     <= COORD_W'(round_y[A-1:F]);
                    pixel_reg.pixel_color <= color_reg;
                    pixel_reg.last_pixel  <= (cnt_reg == len_reg);
                    acc_x_reg             <= acc_x_reg + inc_x_reg;
                    acc_y_reg             <= acc_y_reg + inc_y_reg;
                    cnt_reg               <= cnt_reg + 1'b1;
                    if (cnt_reg == len_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign pixel  = pixel_reg;

endmodule

FILE: design/dda_line_rasterizer_unit.sv
// top level of the dda line rasteriser: front end, segment queue, back end
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------
//  segment   | in        | start high, busy low | endpoints and colour
//  pixel     | out       | strobe, one cycle    | pixel position, colour, last
//
// a segment of length L (larger of |dx| and |dy|) is taken from the queue in the idle state,
// goes through the two per-axis restoring dividers, which run side by side, and then makes
// L + 1 pixel transfers, one per cycle; a point (L = 0) skips the dividers;
// the queue holds two segments, so the next is taken while the current one is drawn;
// busy is high only while the queue is full
// reset is asynchronous, active low; the receiver cannot stall, every strobe is a transfer
`include "assert_macros.svh"

module dda_line_rasterizer_unit #(
    parameter int COORD_BITS = dda_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dda_pkg::seg_in_t    segment,
    output logic                strobe,
    output dda_pkg::pixel_out_t pixel
);
    import dda_pkg::*;

    localparam int SEG_W = seg_width(COORD_BITS);

    // queue status shared by both ends
    queue_stat_t      q_stat;
    logic             push;
    logic             pop;
    logic [SEG_W-1:0] push_entry;
    logic [SEG_W-1:0] head_entry;

    // classify the incoming segment into deltas, length and directions
    dda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .start   (start),
        .segment (segment),
        .q_stat  (q_stat),
        .busy    (busy),
        .push    (push),
        .entry   (push_entry)
    );

    // decouples acceptance from drawing
    dda_queue #(
        .WIDTH (SEG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_entry),
        .pop     (pop),
        .rd_data (head_entry),
        .q_stat  (q_stat)
    );

    // divide for the increments, then step the accumulators
    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .entry  (head_entry),
        .pop    (pop),
        .strobe (strobe),
        .pixel  (pixel)
    );

    // the back end never takes from an empty queue
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)
    // an accepted segment is held in the queue on the next cycle
    `ASSERT_NEXT(a_push_lands, clk, rst_n, start && !busy, !q_stat.empty)
    // the last pixel of a segment is followed by a gap while the next is fetched
    `ASSERT_NEXT(a_gap_after_last, clk, rst_n, strobe && pixel.last_pixel, !strobe)

endmodule
